@@ hw/rtl/cle_pkg.sv @@
// Shared types and constants for the cursor list engine.
// Holds request codes, status codes and the controller/datapath interface structs.
// No dependencies.
package cle_pkg;

    // Field widths fixed by the item format.
    localparam int REQ_W  = 3;
    localparam int CHAR_W = 8;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 9;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TAKE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CHANGE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RIGHT  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_FIRST  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd6;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd7;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_AT_END = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // latch the request and read the cursor node
        logic rd_second; // read the second node
        logic execute;   // apply the request, first memory write
        logic wr_second; // second link write
        logic load_out;  // move the result into the output register
    } cle_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_wr2;  // the request being executed needs a second link write
    } cle_sts_t;

endpackage

@@ hw/rtl/cle_ctrl.sv @@
// Sequencing controller for the cursor list engine.
// Drives the datapath commands and owns the handshakes of both channels.
// Depends on cle_pkg.
module cle_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output cle_pkg::cle_cmd_t cmd,
    input  cle_pkg::cle_sts_t sts
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD2  = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_WR2  = 3'd3;
    localparam logic [2:0] ST_PUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_RD2;
                end
            end
            ST_RD2:
            begin
                cmd.rd_second = 1'b1;
                state_next    = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = sts.need_wr2 ? ST_WR2 : ST_PUT;
            end
            ST_WR2:
            begin
                cmd.wr_second = 1'b1;
                state_next    = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output beat stays valid until the receiver takes it.
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An accepted beat always starts the second read stage.
    a_accept_to_rd2: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == ST_RD2)
        else $error("accepted request did not move to the second read");

    // A result only becomes valid from the result hand-over state.
    a_valid_from_put: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_PUT)
        else $error("output became valid outside the hand-over state");

endmodule

@@ hw/rtl/cle_dpath.sv @@
// Datapath of the cursor list engine: node memories, list pointers, allocator
// and the result register. Commanded by cle_ctrl. Depends on cle_pkg.
module cle_dpath
#(
    parameter int NODES = 256
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cle_pkg::cle_cmd_t                 cmd,
    output cle_pkg::cle_sts_t                 sts,
    input  logic [cle_pkg::REQ_W-1:0]         req_type,
    input  logic [cle_pkg::CHAR_W-1:0]        new_value,
    output logic [cle_pkg::STAT_W-1:0]        status,
    output logic [cle_pkg::CHAR_W-1:0]        value,
    output logic                              is_empty,
    output logic                              at_end,
    output logic [cle_pkg::LEN_W-1:0]         length
);

    localparam int PW = $clog2(NODES + 1);
    localparam int AW = $clog2(NODES);
    localparam logic [PW-1:0] NIL = PW'(NODES);

    // Node memories.
    logic [PW-1:0]             link_mem [NODES];
    logic [cle_pkg::CHAR_W-1:0] char_mem [NODES];
    logic [PW-1:0]             link_q;
    logic [cle_pkg::CHAR_W-1:0] char_q;

    // List and allocator state.
    logic [PW-1:0] head_reg,   head_next;
    logic [PW-1:0] cursor_reg, cursor_next;
    logic [PW-1:0] pool_reg,   pool_next;
    logic [PW-1:0] nun_reg,    nun_next;
    logic [PW-1:0] count_reg,  count_next;

    // Request and first-read captures.
    logic [cle_pkg::REQ_W-1:0]  req_reg;
    logic [cle_pkg::CHAR_W-1:0] nv_reg;
    logic [PW-1:0]              nxt_reg;
    logic [cle_pkg::CHAR_W-1:0] cchar_reg;

    // Second link write, held from execute.
    logic          w2_en_reg,  w2_en_next;
    logic [PW-1:0] w2_ptr_reg, w2_ptr_next;
    logic [PW-1:0] w2_data_reg, w2_data_next;

    // Result held between execute and hand-over, then the output register.
    logic [cle_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [cle_pkg::CHAR_W-1:0] res_value_reg,  res_value_next;
    logic                       res_at_end_reg, res_at_end_next;
    logic [cle_pkg::STAT_W-1:0] out_status_reg;
    logic [cle_pkg::CHAR_W-1:0] out_value_reg;
    logic                       out_empty_reg;
    logic                       out_at_end_reg;
    logic [cle_pkg::LEN_W-1:0]  out_length_reg;

    // Execute-stage combinational signals.
    logic                       empty;
    logic                       nxt_ok;
    logic                       from_pool;
    logic                       alloc_ok;
    logic [PW-1:0]              new_node;
    logic                       w1_link_we;
    logic                       w1_char_we;
    logic [PW-1:0]              w1_ptr;
    logic [PW-1:0]              w1_link;

    // Memory port selection.
    logic                       rd_en;
    logic [PW-1:0]              rd_ptr;
    logic [PW-1:0]              rd2_ptr;
    logic                       link_we;
    logic [PW-1:0]              link_wptr;
    logic [PW-1:0]              link_wdata;

    assign empty     = (cursor_reg == NIL);
    assign nxt_ok    = (nxt_reg != NIL);
    assign from_pool = (pool_reg != NIL);
    assign alloc_ok  = from_pool || (nun_reg != NIL);
    assign new_node  = from_pool ? pool_reg : nun_reg;

    // Second read: pool head for add, head for cursor-to-first, else the
    // node after the cursor that the first read has just returned.
    always_comb
    begin
        if (req_reg == cle_pkg::REQ_ADD)
        begin
            rd2_ptr = pool_reg;
        end
        else if (req_reg == cle_pkg::REQ_FIRST)
        begin
            rd2_ptr = head_reg;
        end
        else if (!empty)
        begin
            rd2_ptr = link_q;
        end
        else
        begin
            rd2_ptr = NIL;
        end
    end

    assign rd_ptr = cmd.accept ? cursor_reg : rd2_ptr;
    assign rd_en  = (cmd.accept || cmd.rd_second) && (rd_ptr != NIL);

    // One link write port, shared by the execute and second-write steps.
    assign link_we    = (cmd.execute && w1_link_we) || (cmd.wr_second && w2_en_reg);
    assign link_wptr  = cmd.execute ? w1_ptr : w2_ptr_reg;
    assign link_wdata = cmd.execute ? w1_link : w2_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            link_q <= link_mem[rd_ptr[AW-1:0]];
            char_q <= char_mem[rd_ptr[AW-1:0]];
        end
        if (link_we)
        begin
            link_mem[link_wptr[AW-1:0]] <= link_wdata;
        end
        if (cmd.execute && w1_char_we)
        begin
            char_mem[w1_ptr[AW-1:0]] <= nv_reg;
        end
    end

    // Request execution: new pointers, memory writes and the result.
    always_comb
    begin
        head_next       = head_reg;
        cursor_next     = cursor_reg;
        pool_next       = pool_reg;
        nun_next        = nun_reg;
        count_next      = count_reg;
        res_status_next = cle_pkg::STAT_OK;
        res_value_next  = '0;
        res_at_end_next = !empty && !nxt_ok;
        w1_link_we      = 1'b0;
        w1_char_we      = 1'b0;
        w1_ptr          = cursor_reg;
        w1_link         = nxt_reg;
        w2_en_next      = 1'b0;
        w2_ptr_next     = cursor_reg;
        w2_data_next    = new_node;
        if (req_reg == cle_pkg::REQ_ADD)
        begin
            if (!alloc_ok)
            begin
                res_status_next = cle_pkg::STAT_FULL;
            end
            else
            begin
                if (from_pool)
                begin
                    pool_next = link_q;
                end
                else
                begin
                    nun_next = nun_reg + PW'(1);
                end
                count_next = count_reg + PW'(1);
                w1_link_we = 1'b1;
                w1_char_we = 1'b1;
                w1_ptr     = new_node;
                if (empty)
                begin
                    w1_link         = NIL;
                    head_next       = new_node;
                    cursor_next     = new_node;
                    res_at_end_next = 1'b1;
                end
                else
                begin
                    w2_en_next      = 1'b1;
                    res_at_end_next = 1'b0;
                end
            end
        end
        else if (empty)
        begin
            res_status_next = cle_pkg::STAT_EMPTY;
        end
        else
        begin
            case (req_reg)
                cle_pkg::REQ_DELETE, cle_pkg::REQ_TAKE:
                begin
                    if (nxt_ok)
                    begin
                        // Unlink the node after the cursor and free it.
                        if (req_reg == cle_pkg::REQ_TAKE)
                        begin
                            res_value_next = char_q;
                        end
                        w1_link_we      = 1'b1;
                        w1_link         = link_q;
                        w2_en_next      = 1'b1;
                        w2_ptr_next     = nxt_reg;
                        w2_data_next    = pool_reg;
                        pool_next       = nxt_reg;
                        count_next      = count_reg - PW'(1);
                        res_at_end_next = (link_q == NIL);
                    end
                    else if (count_reg == PW'(1))
                    begin
                        // Lone element: the list becomes empty.
                        if (req_reg == cle_pkg::REQ_TAKE)
                        begin
                            res_value_next = cchar_reg;
                        end
                        w1_link_we      = 1'b1;
                        w1_link         = pool_reg;
                        pool_next       = cursor_reg;
                        count_next      = count_reg - PW'(1);
                        head_next       = NIL;
                        cursor_next     = NIL;
                        res_at_end_next = 1'b0;
                    end
                    else
                    begin
                        res_status_next = cle_pkg::STAT_AT_END;
                    end
                end
                cle_pkg::REQ_CHANGE:
                begin
                    w1_char_we = 1'b1;
                    w1_ptr     = nxt_ok ? nxt_reg : cursor_reg;
                end
                cle_pkg::REQ_RIGHT:
                begin
                    if (nxt_ok)
                    begin
                        cursor_next     = nxt_reg;
                        res_at_end_next = (link_q == NIL);
                    end
                    else
                    begin
                        res_status_next = cle_pkg::STAT_AT_END;
                    end
                end
                cle_pkg::REQ_FIRST:
                begin
                    cursor_next     = head_reg;
                    res_at_end_next = (link_q == NIL);
                end
                cle_pkg::REQ_CLEAR:
                begin
                    head_next       = NIL;
                    cursor_next     = NIL;
                    pool_next       = NIL;
                    nun_next        = '0;
                    count_next      = '0;
                    res_at_end_next = 1'b0;
                end
                default:
                begin
                    res_value_next = nxt_ok ? char_q : cchar_reg;
                end
            endcase
        end
    end

    assign sts.need_wr2 = w2_en_next;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= NIL;
            cursor_reg <= NIL;
            pool_reg   <= NIL;
            nun_reg    <= '0;
            count_reg  <= '0;
            w2_en_reg  <= 1'b0;
        end
        else if (cmd.execute)
        begin
            head_reg   <= head_next;
            cursor_reg <= cursor_next;
            pool_reg   <= pool_next;
            nun_reg    <= nun_next;
            count_reg  <= count_next;
            w2_en_reg  <= w2_en_next;
        end
    end

    // Payload captures.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req_type;
            nv_reg  <= new_value;
        end
        if (cmd.rd_second)
        begin
            nxt_reg   <= empty ? NIL : link_q;
            cchar_reg <= char_q;
        end
        if (cmd.execute)
        begin
            w2_ptr_reg     <= w2_ptr_next;
            w2_data_reg    <= w2_data_next;
            res_status_reg <= res_status_next;
            res_value_reg  <= res_value_next;
            res_at_end_reg <= res_at_end_next;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_empty_reg  <= (cursor_reg == NIL);
            out_at_end_reg <= res_at_end_reg;
            out_length_reg <= cle_pkg::LEN_W'(count_reg);
        end
    end

    assign status   = out_status_reg;
    assign value    = out_value_reg;
    assign is_empty = out_empty_reg;
    assign at_end   = out_at_end_reg;
    assign length   = out_length_reg;

    // The cursor is null exactly when the list holds no element.
    a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg == NIL) == (count_reg == '0))
        else $error("cursor and element count disagree on emptiness");

    // Head and cursor are null together.
    a_head_cursor_null: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NIL) == (cursor_reg == NIL))
        else $error("head and cursor disagree on emptiness");

    // The element count never exceeds the store.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NIL)
        else $error("element count beyond the node store");

endmodule

@@ hw/rtl/cursor_list_engine_top.sv @@
// Top level of the cursor list engine: stream ports, controller and datapath.
// Depends on cle_pkg, cle_ctrl and cle_dpath.
//
// Usage: each slave beat carries one request on a singly linked list of
// characters held in a node store of NODES entries; each request gives
// exactly one master beat with status, value, empty and end flags and the
// list length. Requests are add after cursor, delete, take, change, move
// right, cursor to first, clear and query.
// Steps: the accepted request reads the cursor node, then a second node, then
// executes with the first memory write, then makes a second link write when
// needed (add to a non-empty list, delete or take of the node after the
// cursor), then loads the result into the output register. A new request is
// accepted only after that load. The single-port node memory takes one read of
// the cursor node, one read of a second node, and one or two link writes per
// request. Clear resets pointers and allocator in one step, not walking the store.
// Reset: the list is empty and every node is free; the node memory itself is
// not cleared and needs no clearing pass.
// Stall: a result waits in the output register until m_tready; the next
// request may be accepted and worked on meanwhile, and only its hand-over
// waits for the output register to drain.
module cursor_list_engine_top
#(
    parameter int NODES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [2:0] req_type, [10:3] new_value, [15:11] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // [1:0] status, [9:2] value, [10] is_empty,
                                  // [11] at_end, [20:12] length, [23:21] zero
);

    cle_pkg::cle_cmd_t             cmd;
    cle_pkg::cle_sts_t             sts;
    logic [cle_pkg::STAT_W-1:0]    status;
    logic [cle_pkg::CHAR_W-1:0]    value;
    logic                          is_empty;
    logic                          at_end;
    logic [cle_pkg::LEN_W-1:0]     length;

    cle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    cle_dpath #(
        .NODES (NODES)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_type  (s_tdata[2:0]),
        .new_value (s_tdata[10:3]),
        .status    (status),
        .value     (value),
        .is_empty  (is_empty),
        .at_end    (at_end),
        .length    (length)
    );

    // Pack the result beat, first field in the lowest bits.
    assign m_tdata = {3'b000, length, at_end, is_empty, value, status};

endmodule
